/* hdl/tcc_pkg.sv */
// Shared constants, types and helper functions of the text console engine.
package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Port field types
  typedef logic [15:0] cell_t;
  typedef logic [7:0]  char_t;
  typedef logic [3:0]  color_t;
  typedef logic [4:0]  port_row_t;
  typedef logic [6:0]  port_col_t;

  // Control characters
  localparam char_t CHAR_TAB   = 8'd9;
  localparam char_t CHAR_NL    = 8'd10;
  localparam char_t CHAR_CR    = 8'd13;
  localparam char_t CHAR_SPACE = 8'h20;

  // Colors after reset and the blank cell they give
  localparam color_t RESET_FG    = 4'd7;
  localparam color_t RESET_BG    = 4'd0;
  localparam cell_t  RESET_BLANK = {RESET_BG, RESET_FG, CHAR_SPACE};

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  // Cursor update for one put transaction
  typedef struct packed {
    row_t row;
    col_t col;
    logic scroll;
    logic write_cell;
  } cursor_upd_t;

  // Screen row to memory row: the store is a ring of rows starting at top
  function automatic row_t phys_row(row_t logical, row_t top);
    logic [ROW_W:0] sum;
    sum = {1'b0, logical} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) sum = sum - (ROW_W + 1)'(ROWS);
    return sum[ROW_W-1:0];
  endfunction

  function automatic addr_t cell_addr(row_t r, col_t c);
    return ADDR_W'(int'(r) * COLUMNS) + ADDR_W'(c);
  endfunction

  function automatic cell_t make_cell(color_t bg, color_t fg, char_t ch);
    return {bg, fg, ch};
  endfunction

endpackage

/* hdl/tcc_if.sv */
// Valid/ready channel interfaces for the console input and result transactions.
interface tcc_in_if;
  logic                valid;
  logic                ready;
  logic                operation;
  tcc_pkg::char_t      char_code;
  tcc_pkg::port_row_t  read_row;
  tcc_pkg::port_col_t  read_col;

  modport source (output valid, operation, char_code, read_row, read_col, input ready);
  modport sink   (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface tcc_out_if;
  logic                valid;
  logic                ready;
  tcc_pkg::cell_t      cell_value;
  tcc_pkg::port_row_t  cursor_row;
  tcc_pkg::port_col_t  cursor_col;
  logic                scrolled;

  modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

/* hdl/tcc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tcc_cursor.sv */
// Next-cursor logic for a put: control characters, tab stops, wrap and scroll.
module tcc_cursor (
  input  tcc_pkg::row_t        row,
  input  tcc_pkg::col_t        col,
  input  tcc_pkg::char_t       char_code,
  output tcc_pkg::cursor_upd_t upd
);

  logic [tcc_pkg::COL_W:0] col_sum;
  logic [tcc_pkg::ROW_W:0] row_inc;
  logic                    newline;

  always_comb begin
    col_sum         = '0;
    newline         = 1'b0;
    upd.row         = row;
    upd.col         = col;
    upd.scroll      = 1'b0;
    upd.write_cell  = 1'b0;
    row_inc         = {1'b0, row} + 1'b1;

    // Column movement per character class
    unique case (char_code)
      tcc_pkg::CHAR_NL: begin
        newline = 1'b1;
      end
      tcc_pkg::CHAR_CR: begin
        upd.col = '0;
      end
      tcc_pkg::CHAR_TAB: begin
        col_sum = ({1'b0, col} + (tcc_pkg::COL_W + 1)'(4)) & ~(tcc_pkg::COL_W + 1)'(3);
        if (col_sum >= (tcc_pkg::COL_W + 1)'(tcc_pkg::COLUMNS)) newline = 1'b1;
        else upd.col = col_sum[tcc_pkg::COL_W-1:0];
      end
      default: begin
        upd.write_cell = 1'b1;
        col_sum        = {1'b0, col} + 1'b1;
        if (col_sum >= (tcc_pkg::COL_W + 1)'(tcc_pkg::COLUMNS)) newline = 1'b1;
        else upd.col = col_sum[tcc_pkg::COL_W-1:0];
      end
    endcase

    // Line feed; leaving the last row scrolls
    if (newline) begin
      upd.col = '0;
      if (row_inc >= (tcc_pkg::ROW_W + 1)'(tcc_pkg::ROWS)) begin
        upd.scroll = 1'b1;
        upd.row    = tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1);
      end else begin
        upd.row = row_inc[tcc_pkg::ROW_W-1:0];
      end
    end
  end

endmodule

/* hdl/text_console_cursor_engine.sv */
// Text console engine top level: screen memory, sequencer, cursor and result register.
//
// Input channel in_chan carries put (character byte) and read (row, column)
// transactions; the result channel out_chan returns one transaction per input:
// the cell read (0 for a put), the cursor after the item and a scroll flag.
// Colors are set through cfg_we/cfg_index/cfg_wdata (0 foreground, 1 background).
// The screen is a ring of rows in one memory with a top-row pointer, so a
// scroll moves the pointer and clears one row instead of copying the screen.
// A put without scroll has its result valid in the cycle after acceptance, and a
// new put can follow each cycle while the receiver takes every result. A read
// passes through the registered read port of the memory and then the result
// register. A scroll then writes the recycled row with blanks, one cell per cycle.
// After reset the block clears all ROWS*COLUMNS cells to grey on black spaces
// before it accepts input; configuration writes are taken during that pass. The
// result register holds while the receiver stalls, and the next item is taken
// only once that result is being drained.
module text_console_cursor_engine (
  input  logic             clk,
  input  logic             rst_n,
  tcc_in_if.sink           in_chan,
  tcc_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  tcc_pkg::color_t  cfg_wdata
);

  tcc_pkg::state_t      state_r, state_nxt;
  tcc_pkg::row_t        row_r, row_nxt;
  tcc_pkg::col_t        col_r, col_nxt;
  tcc_pkg::row_t        top_r, top_nxt;
  tcc_pkg::color_t      fg_r, bg_r;
  tcc_pkg::cell_t       blank_r, blank_nxt;
  tcc_pkg::addr_t       clr_addr_r, clr_addr_nxt;
  tcc_pkg::addr_t       sweep_addr_r, sweep_addr_nxt;
  tcc_pkg::col_t        sweep_cnt_r, sweep_cnt_nxt;
  logic                 range_ok_r, range_ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tcc_pkg::cell_t       out_cell_r;
  tcc_pkg::port_row_t   out_row_r;
  tcc_pkg::port_col_t   out_col_r;
  logic                 out_scrolled_r;

  logic                 in_accept;
  logic                 rd_in_range;
  tcc_pkg::addr_t       rd_addr;
  tcc_pkg::addr_t       put_addr;
  tcc_pkg::cell_t       rd_data;
  tcc_pkg::cursor_upd_t upd;

  logic                 out_load;
  tcc_pkg::cell_t       load_cell;
  tcc_pkg::port_row_t   load_row;
  tcc_pkg::port_col_t   load_col;
  logic                 load_scrolled;

  logic                 mem_we;
  tcc_pkg::addr_t       mem_waddr;
  tcc_pkg::cell_t       mem_wdata;

  // Handshake: one item at a time, overlapped with draining the last result
  assign in_chan.ready = (state_r == tcc_pkg::ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Address mapping through the ring of rows
  assign rd_in_range = (int'(in_chan.read_row) < tcc_pkg::ROWS) &&
                       (int'(in_chan.read_col) < tcc_pkg::COLUMNS);
  assign rd_addr  = tcc_pkg::cell_addr(
                      tcc_pkg::phys_row(tcc_pkg::ROW_W'(in_chan.read_row), top_r),
                      tcc_pkg::COL_W'(in_chan.read_col));
  assign put_addr = tcc_pkg::cell_addr(tcc_pkg::phys_row(row_r, top_r), col_r);

  tcc_cursor u_cursor (
    .row       (row_r),
    .col       (col_r),
    .char_code (in_chan.char_code),
    .upd       (upd)
  );

  // Screen memory; reads happen only in idle, so no write can race them
  tcc_ram #(
    .WIDTH ($bits(tcc_pkg::cell_t)),
    .DEPTH (tcc_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Memory write port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = put_addr;
    mem_wdata = tcc_pkg::make_cell(bg_r, fg_r, in_chan.char_code);
    unique case (state_r)
      tcc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = tcc_pkg::RESET_BLANK;
      end
      tcc_pkg::ST_IDLE: begin
        mem_we = in_accept && (in_chan.operation == tcc_pkg::OP_PUT) && upd.write_cell;
      end
      tcc_pkg::ST_READ: begin
        mem_we = 1'b0;
      end
      tcc_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        mem_wdata = blank_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    top_nxt        = top_r;
    blank_nxt      = blank_r;
    clr_addr_nxt   = clr_addr_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    range_ok_nxt   = range_ok_r;
    out_load       = 1'b0;
    load_cell      = '0;
    load_row       = tcc_pkg::port_row_t'(row_r);
    load_col       = tcc_pkg::port_col_t'(col_r);
    load_scrolled  = 1'b0;

    unique case (state_r)
      tcc_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == tcc_pkg::ADDR_W'(tcc_pkg::CELL_COUNT - 1)) begin
          state_nxt = tcc_pkg::ST_IDLE;
        end
      end
      tcc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_chan.operation == tcc_pkg::OP_READ) begin
            range_ok_nxt = rd_in_range;
            state_nxt    = tcc_pkg::ST_READ;
          end else begin
            row_nxt       = upd.row;
            col_nxt       = upd.col;
            out_load      = 1'b1;
            load_row      = tcc_pkg::port_row_t'(upd.row);
            load_col      = tcc_pkg::port_col_t'(upd.col);
            load_scrolled = upd.scroll;
            // Old top row becomes the new bottom row; blank it with current colors
            if (upd.scroll) begin
              top_nxt = (top_r == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1)) ? '0 : top_r + 1'b1;
              sweep_addr_nxt = tcc_pkg::cell_addr(top_r, '0);
              sweep_cnt_nxt  = '0;
              blank_nxt      = tcc_pkg::make_cell(bg_r, fg_r, tcc_pkg::CHAR_SPACE);
              state_nxt      = tcc_pkg::ST_SWEEP;
            end
          end
        end
      end
      tcc_pkg::ST_READ: begin
        out_load  = 1'b1;
        load_cell = range_ok_r ? rd_data : '0;
        state_nxt = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        sweep_cnt_nxt  = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == tcc_pkg::COL_W'(tcc_pkg::COLUMNS - 1)) begin
          state_nxt = tcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcc_pkg::ST_CLEAR;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcc_pkg::ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      fg_r        <= tcc_pkg::RESET_FG;
      bg_r        <= tcc_pkg::RESET_BG;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tcc_pkg::CFG_FOREGROUND: fg_r <= cfg_wdata;
          tcc_pkg::CFG_BACKGROUND: bg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blank_r      <= blank_nxt;
    sweep_addr_r <= sweep_addr_nxt;
    sweep_cnt_r  <= sweep_cnt_nxt;
    range_ok_r   <= range_ok_nxt;
    if (out_load) begin
      out_cell_r     <= load_cell;
      out_row_r      <= load_row;
      out_col_r      <= load_col;
      out_scrolled_r <= load_scrolled;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_value = out_cell_r;
  assign out_chan.cursor_row = out_row_r;
  assign out_chan.cursor_col = out_col_r;
  assign out_chan.scrolled   = out_scrolled_r;

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < tcc_pkg::ROWS) && (int'(col_r) < tcc_pkg::COLUMNS))
    else $error("cursor outside the screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |->
      (row_r == tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1)) && (col_r == '0))
    else $error("scrolled result without cursor at start of last row");

  a_waddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < tcc_pkg::CELL_COUNT))
    else $error("screen write beyond the memory");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_chan.operation == tcc_pkg::OP_READ)) |=> ##1 out_valid_r)
    else $error("read transaction produced no result");
`endif

endmodule

/* tb/sv/text_console_cursor_checker.sv */
`timescale 1ns / 1ps
// Checker of the text console engine: tracks the screen and cursor and compares every result.
module text_console_cursor_checker (
  input  logic            clk,
  input  logic            rst_n,
  tcc_in_if               in_mon,
  tcc_out_if              out_mon,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  tcc_pkg::color_t cfg_wdata,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic               operation;
    tcc_pkg::char_t     char_code;
    tcc_pkg::port_row_t read_row;
    tcc_pkg::port_col_t read_col;
  } console_cmd_t;

  typedef struct packed {
    tcc_pkg::cell_t     cell_value;
    tcc_pkg::port_row_t cursor_row;
    tcc_pkg::port_col_t cursor_col;
    logic               scrolled;
  } console_report_t;

  // Shadow copy of the screen, the cursor and the colors
  tcc_pkg::cell_t  screen_mem [tcc_pkg::ROWS][tcc_pkg::COLUMNS];
  int              row_pos;
  int              col_pos;
  tcc_pkg::color_t fg_color;
  tcc_pkg::color_t bg_color;
  console_report_t predicted_reports [$];
  console_report_t got;
  console_report_t want;
  int              error_total = 0;

  // Go to column 0 of the next row; leaving the bottom row scrolls the screen
  function automatic logic line_feed();
    col_pos = 0;
    row_pos++;
    if (row_pos < tcc_pkg::ROWS) return 1'b0;
    for (int r = 0; r < tcc_pkg::ROWS - 1; r++)
      for (int c = 0; c < tcc_pkg::COLUMNS; c++)
        screen_mem[r][c] = screen_mem[r + 1][c];
    // new bottom row takes the colors in force at the time of the scroll
    for (int c = 0; c < tcc_pkg::COLUMNS; c++)
      screen_mem[tcc_pkg::ROWS - 1][c] = {bg_color, fg_color, tcc_pkg::CHAR_SPACE};
    row_pos = tcc_pkg::ROWS - 1;
    return 1'b1;
  endfunction

  // Apply one command to the shadow state and give the result it must produce
  function automatic console_report_t console_apply(console_cmd_t cmd);
    console_report_t rep;
    rep = '0;
    if (cmd.operation == tcc_pkg::OP_READ) begin
      // out-of-range addresses read as zero
      if (int'(cmd.read_row) < tcc_pkg::ROWS && int'(cmd.read_col) < tcc_pkg::COLUMNS)
        rep.cell_value = screen_mem[cmd.read_row][cmd.read_col];
    end else begin
      case (cmd.char_code)
        tcc_pkg::CHAR_NL: rep.scrolled = line_feed();
        tcc_pkg::CHAR_CR: col_pos = 0;
        tcc_pkg::CHAR_TAB: begin
          col_pos = (col_pos + 4) & ~3;
          if (col_pos >= tcc_pkg::COLUMNS) rep.scrolled = line_feed();
        end
        default: begin
          screen_mem[row_pos][col_pos] = {bg_color, fg_color, cmd.char_code};
          col_pos++;
          if (col_pos >= tcc_pkg::COLUMNS) rep.scrolled = line_feed();
        end
      endcase
    end
    rep.cursor_row = tcc_pkg::port_row_t'(row_pos);
    rep.cursor_col = tcc_pkg::port_col_t'(col_pos);
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < tcc_pkg::ROWS; r++)
        for (int c = 0; c < tcc_pkg::COLUMNS; c++)
          screen_mem[r][c] = tcc_pkg::RESET_BLANK;
      row_pos  = 0;
      col_pos  = 0;
      fg_color = tcc_pkg::RESET_FG;
      bg_color = tcc_pkg::RESET_BG;
      predicted_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == tcc_pkg::CFG_FOREGROUND) fg_color = cfg_wdata;
        else bg_color = cfg_wdata;
      end
      // results first: a result never leaves in the cycle its transaction is taken
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.cell_value, out_mon.cursor_row, out_mon.cursor_col, out_mon.scrolled};
        if (predicted_reports.size() == 0) begin
          error_total++;
          $display("%0t: unexpected result: expected none, actual %h/%0d/%0d/%b",
                   $time, got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
        end else begin
          want = predicted_reports.pop_front();
          if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
              got.cursor_col !== want.cursor_col || got.scrolled !== want.scrolled) begin
            error_total++;
            // fields in order: cell, row, column, scrolled
            $display("%0t: mismatch: expected %h/%0d/%0d/%b, actual %h/%0d/%0d/%b",
                     $time, want.cell_value, want.cursor_row, want.cursor_col, want.scrolled,
                     got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predicted_reports.push_back(console_apply('{in_mon.operation, in_mon.char_code,
                                                    in_mon.read_row, in_mon.read_col}));
    end
    fail_count <= error_total;
    pending    <= predicted_reports.size();
  end

endmodule

/* tb/sv/text_console_cursor_engine_test.sv */
`timescale 1ns / 1ps
// Top of the text console engine testbench: clock, reset, stimulus, receiver and verdict.
module text_console_cursor_engine_test;

  localparam int QUIET_LIMIT = 6000;  // covers the clearing pass after reset
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 100;   // scroll sweep plus read latency

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_index;
  tcc_pkg::color_t cfg_wdata;
  int              in_idle_pct;
  int              out_idle_pct;
  int              hold_requests = 0;
  int              quiet_cycles = 0;
  int              fail_count;
  int              pending;

  tcc_in_if  in_chan ();
  tcc_out_if out_chan ();

  text_console_cursor_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  text_console_cursor_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL text_console_cursor_engine");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one transaction, with a random gap first, and wait until it is taken
  task automatic send_cmd(input logic op, input tcc_pkg::char_t ch,
                          input tcc_pkg::port_row_t rr, input tcc_pkg::port_col_t rc);
    if ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.char_code <= ch;
    in_chan.read_row  <= rr;
    in_chan.read_col  <= rc;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Mostly text with line control; reads favor the bottom row where the cursor sits
  task automatic send_random_cmd();
    int                 pick;
    logic               op;
    tcc_pkg::char_t     ch;
    tcc_pkg::port_row_t rr;
    tcc_pkg::port_col_t rc;
    pick = $urandom_range(99);
    op   = tcc_pkg::OP_PUT;
    ch   = tcc_pkg::char_t'($urandom_range(255));
    rr   = tcc_pkg::port_row_t'($urandom_range(31));
    rc   = tcc_pkg::port_col_t'($urandom_range(127));
    if (pick < 15) begin
      op = tcc_pkg::OP_READ;
      rr = ($urandom_range(1)) ? tcc_pkg::port_row_t'(tcc_pkg::ROWS - 1)
                               : tcc_pkg::port_row_t'($urandom_range(tcc_pkg::ROWS - 1));
      rc = tcc_pkg::port_col_t'($urandom_range(tcc_pkg::COLUMNS - 1));
    end else if (pick < 20) begin
      op = tcc_pkg::OP_READ;
    end else if (pick < 38) begin
      ch = tcc_pkg::CHAR_NL;
    end else if (pick < 46) begin
      ch = tcc_pkg::CHAR_TAB;
    end else if (pick < 50) begin
      ch = tcc_pkg::CHAR_CR;
    end else if (pick < 80) begin
      ch = tcc_pkg::char_t'($urandom_range(8'h7e, 8'h21));
    end
    send_cmd(op, ch, rr, rc);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Colors change only while the engine is idle, after any scroll sweep is done
  task automatic set_colors(input tcc_pkg::color_t fg, input tcc_pkg::color_t bg);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tcc_pkg::CFG_FOREGROUND;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_index <= tcc_pkg::CFG_BACKGROUND;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = tcc_pkg::CFG_FOREGROUND;
    cfg_wdata         = '0;
    in_chan.valid     = 1'b0;
    in_chan.operation = tcc_pkg::OP_PUT;
    in_chan.char_code = '0;
    in_chan.read_row  = '0;
    in_chan.read_col  = '0;
    in_idle_pct       = 27;
    out_idle_pct      = 84;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: blank screen corners, out-of-range reads, byte extremes, controls
    send_cmd(tcc_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_READ, 8'h00, tcc_pkg::port_row_t'(tcc_pkg::ROWS - 1),
             tcc_pkg::port_col_t'(tcc_pkg::COLUMNS - 1));
    send_cmd(tcc_pkg::OP_READ, 8'hFF, 5'd31, 7'd127);
    send_cmd(tcc_pkg::OP_READ, 8'h00, tcc_pkg::port_row_t'(tcc_pkg::ROWS), 7'd0);
    send_cmd(tcc_pkg::OP_READ, 8'h00, 5'd0, tcc_pkg::port_col_t'(tcc_pkg::COLUMNS));
    send_cmd(tcc_pkg::OP_PUT, 8'h00, 5'd31, 7'd127);
    send_cmd(tcc_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, 8'h41, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_READ, 8'hFF, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_READ, 8'h0A, 5'd0, 7'd1);
    send_cmd(tcc_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
    send_cmd(tcc_pkg::OP_PUT, tcc_pkg::CHAR_TAB, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, tcc_pkg::CHAR_TAB, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, 8'h7E, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, tcc_pkg::CHAR_CR, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, tcc_pkg::CHAR_NL, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_PUT, tcc_pkg::CHAR_SPACE, 5'd0, 7'd0);
    send_cmd(tcc_pkg::OP_READ, 8'h00, 5'd0, 7'd8);
    send_cmd(tcc_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
    repeat (150) send_random_cmd();

    // Brightest colors; sender slow, receiver fast, one full pause mid-way
    set_colors(4'hF, 4'hF);
    in_idle_pct  = 84;
    out_idle_pct = 27;
    repeat (75) send_random_cmd();
    drain();
    repeat (75) send_random_cmd();

    // Darkest colors, no idling, and a long receiver hold-off under full input
    set_colors(4'h0, 4'h0);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (50) send_random_cmd();
    hold_requests++;
    repeat (100) send_random_cmd();

    set_colors(tcc_pkg::color_t'($urandom_range(15)), tcc_pkg::color_t'($urandom_range(15)));
    repeat (150) send_random_cmd();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS text_console_cursor_engine");
    end else begin
      $display("FAIL text_console_cursor_engine");
    end
    $finish;
  end

endmodule
